>>> rtl/lsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types and constants of the lifetime slot pool: field widths,
// request codes and the command/status bundles between control and datapath.
// ----------------------------------------------------------------------------
package lsp_pkg;

    // field widths fixed by the interface
    localparam int REQ_W        = 2;
    localparam int DELTA_W      = 16;
    localparam int AGE_W        = 32;
    localparam int SLOT_INDEX_W = 10;
    localparam int COUNT_W      = 11;

    // request codes
    localparam logic [REQ_W-1:0] REQ_CREATE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;        // input transfer: latch request, clear step counters
        logic pop_free;       // read top of free stack, decrement free_top
        logic commit;         // install new slot at the end of the active list
        logic use_stack;      // new slot comes from the free stack read data
        logic order_rd;       // read active list at the scan index
        logic slot_rd;        // read age and lifetime of the scanned slot
        logic tick_upd;       // age update, retire or keep
        logic rm_push;        // push scanned slot onto the free stack
        logic total_from_keep;// end of tick: active_total takes the kept count
        logic total_clear;    // end of remove-all: no active slots
        logic load_out;       // load the result register
    } lsp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             free_nonempty;
        logic             can_fresh;
        logic             below_max;
        logic             more;   // scan index below active_total
    } lsp_status_t;

endpackage : lsp_pkg
`default_nettype wire

>>> rtl/lifetime_slot_pool.sv
// From input transfer to result: create decodes, pops the free stack if it is not
// empty and commits; tick and remove-all walk the active list; other codes finish.
// The sequencer works on one request at a time; a tick visits each active slot in
// turn (list read, age/lifetime read, update and write-back on single-port RAMs).
// Reset clears the pool counters and handshakes; the slot memories are not
// initialised and need no clearing pass, so requests are taken right after reset.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lifetime_slot_pool
// Pool of slots with age and lifetime: create, tick with expiry, remove-all.
// ----------------------------------------------------------------------------
module lifetime_slot_pool
    import lsp_pkg::*;
#(
    parameter int MAX_SLOTS = 1024
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [REQ_W-1:0]        req_type,
    input  wire logic [DELTA_W-1:0]      age_step,
    input  wire logic [AGE_W-1:0]        lifetime,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic                         granted,
    output logic [SLOT_INDEX_W-1:0]      slot_index,
    output logic [COUNT_W-1:0]           retired_count,
    output logic [COUNT_W-1:0]           active_count
);

    lsp_cmd_t    cmd;
    lsp_status_t status;

    // sequencer
    lsp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // memories, counters and result register
    lsp_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .req_type      (req_type),
        .age_step      (age_step),
        .lifetime      (lifetime),
        .granted       (granted),
        .slot_index    (slot_index),
        .retired_count (retired_count),
        .active_count  (active_count)
    );

endmodule : lifetime_slot_pool
`default_nettype wire

>>> rtl/lsp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsp_datapath
// Slot memories (active list, free stack, ages, lifetimes), pool counters,
// saturating age update and the result register.
// ----------------------------------------------------------------------------
module lsp_datapath
    import lsp_pkg::*;
#(
    parameter int MAX_SLOTS = 1024
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire lsp_cmd_t                cmd,
    output lsp_status_t                  status,
    input  wire logic [REQ_W-1:0]        req_type,
    input  wire logic [DELTA_W-1:0]      age_step,
    input  wire logic [AGE_W-1:0]        lifetime,
    output logic                         granted,
    output logic [SLOT_INDEX_W-1:0]      slot_index,
    output logic [COUNT_W-1:0]           retired_count,
    output logic [COUNT_W-1:0]           active_count
);

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    // memories
    logic [IDX_W-1:0] order_mem [MAX_SLOTS];
    logic [IDX_W-1:0] free_mem  [MAX_SLOTS];
    logic [AGE_W-1:0] age_mem   [MAX_SLOTS];
    logic [AGE_W-1:0] life_mem  [MAX_SLOTS];

    // request latch
    logic [REQ_W-1:0]   req_reg;
    logic [DELTA_W-1:0] delta_reg;
    logic [AGE_W-1:0]   life_reg;

    // counters
    logic [CNT_W-1:0] active_total_reg, active_total_next;
    logic [CNT_W-1:0] free_top_reg,     free_top_next;
    logic [CNT_W-1:0] fresh_reg,        fresh_next;
    logic [CNT_W-1:0] scan_reg,         scan_next;
    logic [CNT_W-1:0] keep_reg,         keep_next;
    logic [CNT_W-1:0] retired_reg,      retired_next;
    logic             res_granted_reg,  res_granted_next;
    logic [IDX_W-1:0] res_index_reg,    res_index_next;

    // registered read data
    logic [IDX_W-1:0] order_rd_reg;
    logic [IDX_W-1:0] free_rd_reg;
    logic [AGE_W-1:0] age_rd_reg;
    logic [AGE_W-1:0] life_rd_reg;

    logic [IDX_W-1:0] new_slot;
    logic [AGE_W:0]   age_sum;
    logic [AGE_W-1:0] age_new;
    logic             retire;
    logic             push_ok;

    // status
    assign status.req           = req_reg;
    assign status.free_nonempty = (free_top_reg != '0);
    assign status.below_max     = (active_total_reg < MAX_CNT);
    assign status.can_fresh     = (active_total_reg < MAX_CNT) && (fresh_reg < MAX_CNT);
    assign status.more          = (scan_reg < active_total_reg);

    assign new_slot = cmd.use_stack ? free_rd_reg : fresh_reg[IDX_W-1:0];
    assign push_ok  = (free_top_reg < MAX_CNT);

    // saturating age update and retire test
    assign age_sum = {1'b0, age_rd_reg} + {{(AGE_W+1-DELTA_W){1'b0}}, delta_reg};
    assign age_new = age_sum[AGE_W] ? {AGE_W{1'b1}} : age_sum[AGE_W-1:0];
    assign retire  = (age_new >= life_rd_reg);

    // request latch
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg   <= req_type;
            delta_reg <= age_step;
            life_reg  <= lifetime;
        end
    end

    // counter next values
    always_comb
    begin
        active_total_next = active_total_reg;
        free_top_next     = free_top_reg;
        fresh_next        = fresh_reg;
        scan_next         = scan_reg;
        keep_next         = keep_reg;
        retired_next      = retired_reg;
        res_granted_next  = res_granted_reg;
        res_index_next    = res_index_reg;

        if (cmd.capture)
        begin
            scan_next        = '0;
            keep_next        = '0;
            retired_next     = '0;
            res_granted_next = 1'b0;
            res_index_next   = '0;
        end
        if (cmd.pop_free)
        begin
            free_top_next = free_top_reg - ONE_CNT;
        end
        if (cmd.commit)
        begin
            active_total_next = active_total_reg + ONE_CNT;
            if (!cmd.use_stack)
            begin
                fresh_next = fresh_reg + ONE_CNT;
            end
            res_granted_next = 1'b1;
            res_index_next   = new_slot;
        end
        if (cmd.tick_upd)
        begin
            scan_next = scan_reg + ONE_CNT;
            if (retire)
            begin
                retired_next = retired_reg + ONE_CNT;
                if (push_ok)
                begin
                    free_top_next = free_top_reg + ONE_CNT;
                end
            end
            else
            begin
                keep_next = keep_reg + ONE_CNT;
            end
        end
        if (cmd.rm_push)
        begin
            scan_next    = scan_reg + ONE_CNT;
            retired_next = retired_reg + ONE_CNT;
            if (push_ok)
            begin
                free_top_next = free_top_reg + ONE_CNT;
            end
        end
        if (cmd.total_from_keep)
        begin
            active_total_next = keep_reg;
        end
        if (cmd.total_clear)
        begin
            active_total_next = '0;
        end
    end

    // counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_total_reg <= '0;
            free_top_reg     <= '0;
            fresh_reg        <= '0;
            scan_reg         <= '0;
            keep_reg         <= '0;
            retired_reg      <= '0;
            res_granted_reg  <= 1'b0;
            res_index_reg    <= '0;
        end
        else
        begin
            active_total_reg <= active_total_next;
            free_top_reg     <= free_top_next;
            fresh_reg        <= fresh_next;
            scan_reg         <= scan_next;
            keep_reg         <= keep_next;
            retired_reg      <= retired_next;
            res_granted_reg  <= res_granted_next;
            res_index_reg    <= res_index_next;
        end
    end

    // active list: appended on create, compacted on tick
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            order_mem[active_total_reg[IDX_W-1:0]] <= new_slot;
        end
        else if (cmd.tick_upd && !retire)
        begin
            order_mem[keep_reg[IDX_W-1:0]] <= order_rd_reg;
        end
        if (cmd.order_rd)
        begin
            order_rd_reg <= order_mem[scan_reg[IDX_W-1:0]];
        end
    end

    // free stack
    always_ff @(posedge clk)
    begin
        if (((cmd.tick_upd && retire) || cmd.rm_push) && push_ok)
        begin
            free_mem[free_top_reg[IDX_W-1:0]] <= order_rd_reg;
        end
        if (cmd.pop_free)
        begin
            free_rd_reg <= free_mem[free_top_next[IDX_W-1:0]];
        end
    end

    // slot ages
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            age_mem[new_slot] <= '0;
        end
        else if (cmd.tick_upd)
        begin
            age_mem[order_rd_reg] <= age_new;
        end
        if (cmd.slot_rd)
        begin
            age_rd_reg <= age_mem[order_rd_reg];
        end
    end

    // slot lifetimes
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            life_mem[new_slot] <= life_reg;
        end
        if (cmd.slot_rd)
        begin
            life_rd_reg <= life_mem[order_rd_reg];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            granted       <= res_granted_reg;
            slot_index    <= SLOT_INDEX_W'(res_index_reg);
            retired_count <= COUNT_W'(retired_reg);
            active_count  <= COUNT_W'(active_total_reg);
        end
    end

endmodule : lsp_datapath
`default_nettype wire

>>> rtl/lsp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsp_ctrl
// Request sequencer: decodes the latched request, walks the active list for
// tick and remove-all, and drives the input and output handshakes.
// ----------------------------------------------------------------------------
module lsp_ctrl
    import lsp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire lsp_status_t status,
    output lsp_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_POP    = 3'd2;
    localparam logic [2:0] ST_T_ADDR = 3'd3;
    localparam logic [2:0] ST_T_SLOT = 3'd4;
    localparam logic [2:0] ST_T_UPD  = 3'd5;
    localparam logic [2:0] ST_R_ADDR = 3'd6;
    localparam logic [2:0] ST_R_PUSH = 3'd7;
    // finishing is folded into a flag so the state fits three bits
    logic [2:0] state_reg, state_next;
    logic       finish_reg, finish_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE) && !finish_reg;
    assign out_valid = out_valid_reg;

    // sequencing
    always_comb
    begin
        state_next     = state_reg;
        finish_next    = finish_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (finish_reg)
        begin
            // wait for the result register to be free
            if (!out_valid_reg || out_ready)
            begin
                cmd.load_out   = 1'b1;
                out_valid_next = 1'b1;
                finish_next    = 1'b0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_DECODE;
                    end
                end
                ST_DECODE:
                begin
                    case (status.req)
                        REQ_CREATE:
                        begin
                            if (status.free_nonempty)
                            begin
                                cmd.pop_free = 1'b1;
                                state_next   = ST_POP;
                            end
                            else
                            begin
                                cmd.commit  = status.can_fresh;
                                state_next  = ST_IDLE;
                                finish_next = 1'b1;
                            end
                        end
                        REQ_TICK:   state_next = ST_T_ADDR;
                        REQ_REMOVE: state_next = ST_R_ADDR;
                        default:
                        begin
                            state_next  = ST_IDLE;
                            finish_next = 1'b1;
                        end
                    endcase
                end
                ST_POP:
                begin
                    cmd.commit    = status.below_max;
                    cmd.use_stack = 1'b1;
                    state_next    = ST_IDLE;
                    finish_next   = 1'b1;
                end
                ST_T_ADDR:
                begin
                    if (status.more)
                    begin
                        cmd.order_rd = 1'b1;
                        state_next   = ST_T_SLOT;
                    end
                    else
                    begin
                        cmd.total_from_keep = 1'b1;
                        state_next          = ST_IDLE;
                        finish_next         = 1'b1;
                    end
                end
                ST_T_SLOT:
                begin
                    cmd.slot_rd = 1'b1;
                    state_next  = ST_T_UPD;
                end
                ST_T_UPD:
                begin
                    cmd.tick_upd = 1'b1;
                    state_next   = ST_T_ADDR;
                end
                ST_R_ADDR:
                begin
                    if (status.more)
                    begin
                        cmd.order_rd = 1'b1;
                        state_next   = ST_R_PUSH;
                    end
                    else
                    begin
                        cmd.total_clear = 1'b1;
                        state_next      = ST_IDLE;
                        finish_next     = 1'b1;
                    end
                end
                ST_R_PUSH:
                begin
                    cmd.rm_push = 1'b1;
                    state_next  = ST_R_ADDR;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            finish_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            finish_reg    <= finish_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule : lsp_ctrl
`default_nettype wire

>>> sim/lifetime_slot_pool_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifetime_slot_pool_tb
// Self-checking bench for the slot pool. A queue of requests feeds a clocked
// driver, and each input transfer is run through a local model of the pool
// (active list, free stack, ages, lifetimes) to form the expected reply. A
// clocked monitor compares every output transfer with the oldest expected
// reply. Both channels idle and stall at random in several phases.
// ----------------------------------------------------------------------------
module lifetime_slot_pool_tb;
    import lsp_pkg::*;

    localparam int POOL_SLOTS     = 1024;
    localparam int RANDOM_ITEMS   = 560;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES   = 32;
    localparam int MAX_REPORTS    = 10;

    localparam logic [COUNT_W-1:0] POOL_CAP = COUNT_W'(POOL_SLOTS);

    // code the block must ignore
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // idle phases: none, sender only, receiver only, both
    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_SEND = 2'd1;
    localparam logic [1:0] PH_RECV = 2'd2;
    localparam logic [1:0] PH_BOTH = 2'd3;
    localparam int SEND_IDLE_PCT [4] = '{0, 50, 0, 37};
    localparam int RECV_STALL_PCT[4] = '{0, 0, 50, 37};

    typedef struct {
        logic [REQ_W-1:0]   kind;
        logic [DELTA_W-1:0] delta;
        logic [AGE_W-1:0]   life;
        logic [1:0]         phase;
    } pool_request_t;

    typedef struct packed {
        logic                    granted;
        logic [SLOT_INDEX_W-1:0] slot_index;
        logic [COUNT_W-1:0]      retired_count;
        logic [COUNT_W-1:0]      active_count;
    } pool_reply_t;

    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    in_valid      = 1'b0;
    logic                    in_ready;
    logic [REQ_W-1:0]        req_type      = REQ_CREATE;
    logic [DELTA_W-1:0]      age_step      = '0;
    logic [AGE_W-1:0]        lifetime      = '0;
    logic                    out_valid;
    logic                    out_ready     = 1'b0;
    logic                    granted;
    logic [SLOT_INDEX_W-1:0] slot_index;
    logic [COUNT_W-1:0]      retired_count;
    logic [COUNT_W-1:0]      active_count;

    pool_request_t request_queue[$];
    pool_reply_t   expected_replies[$];
    int            stall_pct     = 0;
    int            fail_count    = 0;
    int            quiet_cycles  = 0;

    // pool model state
    logic [SLOT_INDEX_W-1:0] live_order [POOL_SLOTS];
    logic [SLOT_INDEX_W-1:0] free_slots [POOL_SLOTS];
    logic [AGE_W-1:0]        slot_ages  [POOL_SLOTS];
    logic [AGE_W-1:0]        slot_lives [POOL_SLOTS];
    logic [COUNT_W-1:0]      live_total = '0;
    logic [COUNT_W-1:0]      free_depth = '0;
    logic [COUNT_W-1:0]      fresh_slot = '0;

    lifetime_slot_pool #(
        .MAX_SLOTS(POOL_SLOTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .age_step     (age_step),
        .lifetime     (lifetime),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .granted      (granted),
        .slot_index   (slot_index),
        .retired_count(retired_count),
        .active_count (active_count)
    );

    always #6 clk = ~clk;

    // Apply one request to the pool model and return the reply it gives
    function automatic void predict_pool_reply(
        input  logic [REQ_W-1:0]   kind,
        input  logic [DELTA_W-1:0] delta,
        input  logic [AGE_W-1:0]   life,
        output pool_reply_t        reply
    );
        logic [SLOT_INDEX_W-1:0] slot;
        logic [AGE_W:0]          sum;
        logic [AGE_W-1:0]        aged;
        logic [COUNT_W-1:0]      kept;
        logic                    got;
        reply = '0;
        slot  = '0;
        case (kind)
            REQ_CREATE:
            begin
                // free stack first, then a never-used slot
                got = 1'b1;
                if (free_depth != '0)
                begin
                    free_depth = free_depth - 1'b1;
                    slot = free_slots[free_depth[SLOT_INDEX_W-1:0]];
                end
                else if (live_total < POOL_CAP && fresh_slot < POOL_CAP)
                begin
                    slot = fresh_slot[SLOT_INDEX_W-1:0];
                    fresh_slot = fresh_slot + 1'b1;
                end
                else
                begin
                    got = 1'b0;
                end
                if (got && live_total < POOL_CAP)
                begin
                    slot_ages[slot]  = '0;
                    slot_lives[slot] = life;
                    live_order[live_total[SLOT_INDEX_W-1:0]] = slot;
                    live_total       = live_total + 1'b1;
                    reply.granted    = 1'b1;
                    reply.slot_index = slot;
                end
            end
            REQ_TICK:
            begin
                // age in list order, saturating; expired slots go to the stack
                kept = '0;
                for (int i = 0; i < int'(live_total); i++)
                begin
                    slot = live_order[SLOT_INDEX_W'(i)];
                    sum  = {1'b0, slot_ages[slot]} + {{(AGE_W+1-DELTA_W){1'b0}}, delta};
                    aged = sum[AGE_W] ? '1 : sum[AGE_W-1:0];
                    slot_ages[slot] = aged;
                    if (aged >= slot_lives[slot])
                    begin
                        if (free_depth < POOL_CAP)
                        begin
                            free_slots[free_depth[SLOT_INDEX_W-1:0]] = slot;
                            free_depth = free_depth + 1'b1;
                        end
                        reply.retired_count = reply.retired_count + 1'b1;
                    end
                    else
                    begin
                        live_order[kept[SLOT_INDEX_W-1:0]] = slot;
                        kept = kept + 1'b1;
                    end
                end
                live_total = kept;
            end
            REQ_REMOVE:
            begin
                for (int i = 0; i < int'(live_total); i++)
                begin
                    if (free_depth < POOL_CAP)
                    begin
                        free_slots[free_depth[SLOT_INDEX_W-1:0]] =
                            live_order[SLOT_INDEX_W'(i)];
                        free_depth = free_depth + 1'b1;
                    end
                    reply.retired_count = reply.retired_count + 1'b1;
                end
                live_total = '0;
            end
            default:
            begin
            end
        endcase
        reply.active_count = live_total;
    endfunction

    task automatic queue_request(
        input logic [REQ_W-1:0]   kind,
        input logic [DELTA_W-1:0] delta,
        input logic [AGE_W-1:0]   life,
        input logic [1:0]         phase
    );
        pool_request_t item;
        item.kind  = kind;
        item.delta = delta;
        item.life  = life;
        item.phase = phase;
        request_queue.insert(request_queue.size(), item);
    endtask

    // Driver: predicts on each input transfer, then presents the next request
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        pool_request_t head;
        pool_reply_t   reply;
        logic          took;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            req_type <= REQ_CREATE;
            age_step <= '0;
            lifetime <= '0;
        end
        else
        begin
            took = in_valid && in_ready;
            if (took)
            begin
                predict_pool_reply(req_type, age_step, lifetime, reply);
                expected_replies.insert(expected_replies.size(), reply);
            end
            if (!in_valid || took)
            begin
                if (request_queue.size() != 0 &&
                    $urandom_range(99) >= SEND_IDLE_PCT[request_queue[0].phase])
                begin
                    head = request_queue.pop_front();
                    in_valid  <= 1'b1;
                    req_type  <= head.kind;
                    age_step  <= head.delta;
                    lifetime  <= head.life;
                    stall_pct <= RECV_STALL_PCT[head.phase];
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, check each output transfer in order
    always @(posedge clk or negedge rst_n)
    begin : reply_monitor
        pool_reply_t want;
        logic        bad;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected reply: granted=%0d index=%0d retired=%0d active=%0d",
                                 granted, slot_index, retired_count, active_count);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    bad  = (granted       !== want.granted)       ||
                           (slot_index    !== want.slot_index)    ||
                           (retired_count !== want.retired_count) ||
                           (active_count  !== want.active_count);
                    if (bad)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                        begin
                            $display("mismatch: expected granted=%0d index=%0d retired=%0d active=%0d",
                                     want.granted, want.slot_index,
                                     want.retired_count, want.active_count);
                            $display("          actual   granted=%0d index=%0d retired=%0d active=%0d",
                                     granted, slot_index, retired_count, active_count);
                        end
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: cycles without any transfer on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [REQ_W-1:0]   kind;
        logic [DELTA_W-1:0] delta;
        logic [AGE_W-1:0]   life;
        int                 pick;

        // directed: empty pool, zero lifetime, stack reuse, field extremes
        queue_request(REQ_UNUSED, 16'h0000, 32'h0000_0000, PH_NONE);
        queue_request(REQ_TICK,   16'h0003, 32'h0000_0000, PH_NONE);
        queue_request(REQ_REMOVE, 16'h0000, 32'h0000_0000, PH_NONE);
        queue_request(REQ_CREATE, 16'h0000, 32'h0000_0000, PH_NONE);
        queue_request(REQ_CREATE, 16'h0000, 32'hFFFF_FFFF, PH_NONE);
        queue_request(REQ_CREATE, 16'h0000, 32'h0000_0005, PH_NONE);
        queue_request(REQ_TICK,   16'h0000, 32'h0000_0000, PH_NONE);
        queue_request(REQ_TICK,   16'h0004, 32'h0000_0000, PH_NONE);
        queue_request(REQ_TICK,   16'h0001, 32'h0000_0000, PH_NONE);
        queue_request(REQ_CREATE, 16'h0000, 32'h0000_0064, PH_NONE);
        queue_request(REQ_CREATE, 16'h0000, 32'h0000_0064, PH_NONE);
        queue_request(REQ_CREATE, 16'h0000, 32'h0000_0064, PH_NONE);
        queue_request(REQ_TICK,   16'hFFFF, 32'h0000_0000, PH_NONE);
        queue_request(REQ_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, PH_NONE);
        queue_request(REQ_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, PH_NONE);
        queue_request(REQ_CREATE, 16'hFFFF, 32'h0000_0001, PH_NONE);
        queue_request(REQ_CREATE, 16'h5555, 32'hAAAA_AAAA, PH_NONE);
        queue_request(REQ_CREATE, 16'hAAAA, 32'h5555_5555, PH_NONE);
        queue_request(REQ_TICK,   16'h8000, 32'h8000_0000, PH_NONE);
        queue_request(REQ_TICK,   16'hFFFF, 32'h7FFF_FFFF, PH_NONE);
        queue_request(REQ_REMOVE, 16'h0000, 32'h0000_0000, PH_NONE);

        // random mix, idle phase changes every 40 requests
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 48)
                kind = REQ_CREATE;
            else if (pick < 86)
                kind = REQ_TICK;
            else if (pick < 95)
                kind = REQ_REMOVE;
            else
                kind = REQ_UNUSED;
            case ($urandom_range(2))
                0:       delta = DELTA_W'($urandom_range(15));
                1:       delta = DELTA_W'($urandom_range(400));
                default: delta = DELTA_W'($urandom_range(16'hFFFF));
            endcase
            case ($urandom_range(4))
                0:       life = $urandom_range(40);
                1:       life = $urandom_range(3000);
                2:       life = $urandom();
                3:       life = '0;
                default: life = $urandom_range(32'hFFFF_FFFF, 32'hFFFF_0000);
            endcase
            queue_request(kind, delta, life, 2'((n / 40) % 4));
        end

        // reset, then wait for every transfer to complete
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        while (request_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_replies.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
